// ===== rtl/mct_pkg.sv =====
package mct_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [3:0] KIND_TEXT      = 4'd0;
  localparam logic [3:0] KIND_SPACE     = 4'd1;
  localparam logic [3:0] KIND_LESS      = 4'd2;
  localparam logic [3:0] KIND_GREATER   = 4'd3;
  localparam logic [3:0] KIND_EQUALS    = 4'd4;
  localparam logic [3:0] KIND_QUOTE     = 4'd5;
  localparam logic [3:0] KIND_SLASH     = 4'd6;
  localparam logic [3:0] KIND_CMT_OPEN  = 4'd7;
  localparam logic [3:0] KIND_CMT_CLOSE = 4'd8;

  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] char_value;
    logic       starts_token;
    logic       run_last;
    logic       text_done;
  } out_t;

  typedef struct packed {
    logic [2:0]              count;
    out_t [MaxRes-1:0]       res;
  } bundle_t;

endpackage

// ===== rtl/mct_scan.sv =====
module mct_scan
  import mct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_t     in_data,
  output logic    bnd_valid,
  input  logic    bnd_ready,
  output bundle_t bnd_data
);

  localparam logic [1:0] M_NO   = 2'd0;
  localparam logic [1:0] M_YES  = 2'd1;
  localparam logic [1:0] M_WAIT = 2'd2;

  localparam logic [3:0][7:0] OPEN_PAT  = {CH_DASH, CH_DASH, CH_BANG, CH_LESS};
  localparam logic [3:0][7:0] CLOSE_PAT = {8'h00, CH_GREATER, CH_DASH, CH_DASH};

  function automatic logic [1:0] match_pat(input logic [3:0][7:0] win,
                                           input logic [2:0] avail,
                                           input logic is_open,
                                           input logic fin);
    logic [1:0] r;
    logic       dec;
    logic [7:0] pc;
    logic [2:0] len;
    r   = M_YES;
    dec = 1'b0;
    len = is_open ? 3'd4 : 3'd3;
    for (int k = 1; k < 4; k++) begin
      pc = is_open ? OPEN_PAT[k] : CLOSE_PAT[k];
      if (!dec && (3'(k) < len)) begin
        if (3'(k) < avail) begin
          if (win[k] != pc) begin
            r   = M_NO;
            dec = 1'b1;
          end
        end else begin
          r   = fin ? M_NO : M_WAIT;
          dec = 1'b1;
        end
      end
    end
    return r;
  endfunction

  logic       s1_valid_r, s1_valid_nxt;
  in_t        s1_data_r;
  logic [7:0] pend_r [3];
  logic [7:0] pend_nxt [3];
  logic [1:0] pend_cnt_r, pend_cnt_nxt;
  logic [3:0] prev_kind_r, prev_kind_nxt;
  logic       prev_valid_r, prev_valid_nxt;
  logic       advance;

  logic [7:0][7:0] sc_ext;
  logic [3:0][7:0] sc_win;
  logic [2:0]      sc_n;
  logic [2:0]      sc_pos;
  logic [2:0]      sc_avail;
  logic [2:0]      sc_cnt;
  logic [2:0]      sc_last;
  logic [2:0]      sc_adv;
  logic [2:0]      sc_rem;
  logic            sc_act;
  logic            sc_emit;
  logic            sc_merge;
  logic            sc_fin;
  logic [7:0]      sc_c;
  logic [3:0]      sc_kind;
  logic [1:0]      sc_mr;
  logic [3:0]      sc_pk;
  logic            sc_pv;
  out_t [MaxRes-1:0] sc_res;

  always_comb begin
    sc_ext = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pend_cnt_r) begin
        sc_ext[i] = pend_r[i];
      end
    end
    sc_ext[{1'b0, pend_cnt_r}] = s1_data_r.byte_in;
    sc_n     = {1'b0, pend_cnt_r} + 3'd1;
    sc_fin   = s1_data_r.final_byte;
    sc_pos   = '0;
    sc_cnt   = '0;
    sc_act   = 1'b1;
    sc_pk    = prev_kind_r;
    sc_pv    = prev_valid_r;
    sc_res   = '0;
    sc_win   = '0;
    sc_avail = '0;
    sc_c     = '0;
    sc_kind  = KIND_TEXT;
    sc_adv   = '0;
    sc_emit  = 1'b0;
    sc_merge = 1'b0;
    sc_mr    = M_NO;
    for (int s = 0; s < MaxRes; s++) begin
      if (sc_act && (sc_pos < sc_n)) begin
        sc_avail = sc_n - sc_pos;
        for (int k = 0; k < 4; k++) begin
          sc_win[k] = sc_ext[sc_pos + 3'(k)];
        end
        sc_c     = sc_win[0];
        sc_emit  = 1'b1;
        sc_merge = 1'b0;
        sc_adv   = 3'd1;
        sc_kind  = KIND_TEXT;
        sc_mr    = M_NO;
        if (sc_c == CH_LESS) begin
          sc_mr = match_pat(sc_win, sc_avail, 1'b1, sc_fin);
          if (sc_mr == M_WAIT) begin
            sc_act  = 1'b0;
            sc_emit = 1'b0;
          end else if (sc_mr == M_YES) begin
            sc_kind = KIND_CMT_OPEN;
            sc_adv  = 3'd4;
          end else begin
            sc_kind = KIND_LESS;
          end
        end else if (sc_c == CH_DASH) begin
          sc_mr = match_pat(sc_win, sc_avail, 1'b0, sc_fin);
          if (sc_mr == M_WAIT) begin
            sc_act  = 1'b0;
            sc_emit = 1'b0;
          end else if (sc_mr == M_YES) begin
            sc_kind = KIND_CMT_CLOSE;
            sc_adv  = 3'd3;
          end else begin
            sc_kind  = KIND_TEXT;
            sc_merge = 1'b1;
          end
        end else if (sc_c == CH_GREATER) begin
          sc_kind = KIND_GREATER;
        end else if (sc_c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
          sc_kind  = KIND_SPACE;
          sc_merge = 1'b1;
        end else if (sc_c == CH_EQUALS) begin
          sc_kind = KIND_EQUALS;
        end else if (sc_c == CH_QUOTE) begin
          sc_kind = KIND_QUOTE;
        end else if (sc_c == CH_SLASH) begin
          sc_kind = KIND_SLASH;
        end else begin
          sc_kind  = KIND_TEXT;
          sc_merge = 1'b1;
        end
        if (sc_emit) begin
          sc_res[sc_cnt[1:0]].token_kind   = sc_kind;
          sc_res[sc_cnt[1:0]].char_value   = sc_c;
          sc_res[sc_cnt[1:0]].starts_token = !(sc_merge && sc_pv && (sc_pk == sc_kind));
          sc_pk  = sc_kind;
          sc_pv  = 1'b1;
          sc_cnt = sc_cnt + 3'd1;
          sc_pos = sc_pos + sc_adv;
        end
      end
    end
    sc_last = sc_cnt - 3'd1;
    if (sc_cnt != 3'd0) begin
      sc_res[sc_last[1:0]].run_last  = 1'b1;
      sc_res[sc_last[1:0]].text_done = sc_fin;
    end
    sc_rem = sc_n - sc_pos;
    for (int i = 0; i < 3; i++) begin
      pend_nxt[i] = sc_ext[sc_pos + 3'(i)];
    end
    pend_cnt_nxt   = sc_fin ? 2'd0 : sc_rem[1:0];
    prev_kind_nxt  = sc_fin ? KIND_TEXT : sc_pk;
    prev_valid_nxt = sc_fin ? 1'b0 : sc_pv;
  end

  assign bnd_data.count = sc_cnt;
  assign bnd_data.res   = sc_res;
  assign bnd_valid      = s1_valid_r && (sc_cnt != 3'd0);
  assign advance        = s1_valid_r && ((sc_cnt == 3'd0) || bnd_ready);
  assign in_ready       = !s1_valid_r || advance;

  always_comb begin
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pend_cnt_r   <= 2'd0;
      prev_kind_r  <= KIND_TEXT;
      prev_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        pend_cnt_r   <= pend_cnt_nxt;
        prev_kind_r  <= prev_kind_nxt;
        prev_valid_r <= prev_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      pend_r <= pend_nxt;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_data_r.final_byte |=> (pend_cnt_r == 2'd0) && !prev_valid_r)
    else $error("state not cleared after the final byte");

  a_pending_head: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cnt_r != 2'd0) |-> (pend_r[0] == CH_LESS || pend_r[0] == CH_DASH))
    else $error("pending queue does not start with a pattern opener");

  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_data_r.final_byte |-> (sc_cnt != 3'd0))
    else $error("final byte produced no result");

endmodule

// ===== rtl/mct_serial.sv =====
module mct_serial
  import mct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    bnd_valid,
  output logic    bnd_ready,
  input  bundle_t bnd_data,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  out_t [MaxRes-1:0] res_r, res_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              take;
  logic              load;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = res_r[0];
  assign take      = out_valid && out_ready;
  assign bnd_ready = (cnt_r == 3'd0) || (take && (cnt_r == 3'd1));
  assign load      = bnd_valid && bnd_ready;

  always_comb begin
    res_nxt = res_r;
    if (load) begin
      cnt_nxt = bnd_data.count;
      res_nxt = bnd_data.res;
    end else if (take) begin
      cnt_nxt = cnt_r - 3'd1;
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_nxt[i] = res_r[i + 1];
      end
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_last == (cnt_r == 3'd1)))
    else $error("run_last does not match the end of the item's results");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_done |-> out_data.run_last)
    else $error("text_done on a result that is not the item's last");

endmodule

// ===== rtl/markup_char_tokenizer.sv =====
// Markup character tokenizer: one text byte per input transfer, with final_byte set on the
// last byte of a text, and one token record per output transfer. Each byte passes an input
// register, combinational classification (including the comment opener and closer, held back
// in a pending queue of up to three bytes until decided) and a result register that hands
// out the up to four records an item causes, one per cycle while the receiver is ready. A
// byte giving at most one record is taken every cycle unless the output stalls; the next
// item waits while records of an item but its last are still to go out, as there is a
// single output port. A byte that only waits in the pending queue gives no record, and the
// final byte always gives at least one and returns the block to its state after reset.
module markup_char_tokenizer
  import mct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic    bnd_valid;
  logic    bnd_ready;
  bundle_t bnd_data;

  mct_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready),
    .bnd_data  (bnd_data)
  );

  mct_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready),
    .bnd_data  (bnd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/markup_char_tokenizer_test.sv =====
`timescale 1ns / 100ps

module markup_char_tokenizer_test
  import mct_pkg::*;
();

  localparam int CycleLimit = 200000;
  localparam int ReportLimit = 10;
  localparam int PhaseBytes = 44;
  localparam int LongHold = 64;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } probe_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  markup_char_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Tokenizer state as the block should hold it.
  logic [7:0] held_bytes [3];
  int         held_count = 0;
  logic [3:0] last_kind = KIND_TEXT;
  bit         last_seen = 1'b0;
  logic [7:0] win [4];
  out_t       tok_buf [4];
  int         tok_n;

  out_t       due_tokens [$];
  probe_t     probes [$];
  in_t        plan [$];
  logic [7:0] draft [$];

  int sender_idle = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int cycles = 0;
  int mismatches = 0;
  int tokens_seen = 0;
  int comment_tokens = 0;
  int bytes_sent = 0;
  int texts_sent = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pat_byte(bit opener, int k);
    if (k == 0) return opener ? CH_LESS : CH_DASH;
    if (opener) return (k == 1) ? CH_BANG : CH_DASH;
    return (k == 1) ? CH_DASH : CH_GREATER;
  endfunction

  // Returns 1 on a full match, 0 on a mismatch and -1 while undecided.
  function automatic int match_at(int p, int avail, bit opener, bit fin);
    int len;
    len = opener ? 4 : 3;
    for (int k = 1; k < len; k++) begin
      if (k >= avail) return fin ? 0 : -1;
      if (win[p + k] != pat_byte(opener, k)) return 0;
    end
    return 1;
  endfunction

  function automatic void add_token(logic [3:0] kind, logic [7:0] ch, bit merge);
    out_t r;
    r.token_kind = kind;
    r.char_value = ch;
    r.starts_token = !(merge && last_seen && last_kind == kind);
    r.run_last = 1'b0;
    r.text_done = 1'b0;
    tok_buf[tok_n] = r;
    tok_n++;
    last_kind = kind;
    last_seen = 1'b1;
  endfunction

  function automatic void tokenize(in_t item);
    int n, p, m;
    logic [7:0] c;
    bit fin;
    fin = item.final_byte;
    n = held_count;
    for (int i = 0; i < n; i++) win[i] = held_bytes[i];
    win[n] = item.byte_in;
    n++;
    p = 0;
    tok_n = 0;
    while (p < n && tok_n < 4) begin
      c = win[p];
      if (c == CH_LESS) begin
        m = match_at(p, n - p, 1'b1, fin);
        if (m < 0) break;
        if (m > 0) begin
          add_token(KIND_CMT_OPEN, c, 1'b0);
          p += 4;
        end else begin
          add_token(KIND_LESS, c, 1'b0);
          p++;
        end
      end else if (c == CH_DASH) begin
        m = match_at(p, n - p, 1'b0, fin);
        if (m < 0) break;
        if (m > 0) begin
          add_token(KIND_CMT_CLOSE, c, 1'b0);
          p += 3;
        end else begin
          add_token(KIND_TEXT, c, 1'b1);
          p++;
        end
      end else begin
        if (c == CH_GREATER) add_token(KIND_GREATER, c, 1'b0);
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) add_token(KIND_SPACE, c, 1'b1);
        else if (c == CH_EQUALS) add_token(KIND_EQUALS, c, 1'b0);
        else if (c == CH_QUOTE) add_token(KIND_QUOTE, c, 1'b0);
        else if (c == CH_SLASH) add_token(KIND_SLASH, c, 1'b0);
        else add_token(KIND_TEXT, c, 1'b1);
        p++;
      end
    end
    if (tok_n > 0) begin
      tok_buf[tok_n - 1].run_last = 1'b1;
      tok_buf[tok_n - 1].text_done = fin;
    end
    if (fin) begin
      held_count = 0;
      last_kind = KIND_TEXT;
      last_seen = 1'b0;
    end else begin
      held_count = n - p;
      for (int i = 0; i < held_count; i++) held_bytes[i] = win[p + i];
    end
  endfunction

  function automatic void add_probe(logic [7:0] b, logic fin);
    probe_t r;
    r = '0;
    r.item.byte_in = b;
    r.item.final_byte = fin;
    probes.push_back(r);
  endfunction

  // A lone final byte straight after reset gives one token that starts, ends the item and
  // ends the text.
  function automatic void add_fixed(logic [7:0] b, logic [3:0] kind);
    probe_t r;
    r = '0;
    r.item.byte_in = b;
    r.item.final_byte = 1'b1;
    r.typed = 1'b1;
    r.want.token_kind = kind;
    r.want.char_value = b;
    r.want.starts_token = 1'b1;
    r.want.run_last = 1'b1;
    r.want.text_done = 1'b1;
    probes.push_back(r);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'($urandom_range(0, 255));
      1: b = 8'($urandom_range(9, 13));
      2: b = CH_SPACE;
      3: b = CH_LESS;
      4: b = CH_BANG;
      5, 6: b = CH_DASH;
      7: b = CH_GREATER;
      8: begin
        case ($urandom_range(0, 2))
          0: b = CH_EQUALS;
          1: b = CH_QUOTE;
          default: b = CH_SLASH;
        endcase
      end
      default: b = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    return b;
  endfunction

  task automatic add_pattern(bit opener);
    int len, cut, bad;
    len = opener ? 4 : 3;
    cut = len;
    bad = -1;
    case ($urandom_range(0, 5))
      0: cut = $urandom_range(1, len - 1);
      1: bad = $urandom_range(1, len - 1);
      default: ;
    endcase
    for (int k = 0; k < cut; k++)
      draft.push_back((k == bad) ? pick_byte() : pat_byte(opener, k));
  endtask

  task automatic compose_text();
    int goal;
    in_t it;
    goal = $urandom_range(1, 9);
    if ($urandom_range(0, 6) == 0) begin
      repeat (goal) draft.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (draft.size() < goal) begin
        case ($urandom_range(0, 9))
          0, 1: add_pattern(1'b1);
          2, 3: add_pattern(1'b0);
          default: draft.push_back(pick_byte());
        endcase
      end
    end
    foreach (draft[i]) begin
      it.byte_in = draft[i];
      it.final_byte = (i == draft.size() - 1);
      plan.push_back(it);
    end
    draft.delete();
  endtask

  task automatic offer(in_t item, logic typed, out_t want);
    while (sender_idle != 0 && $urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize(item);
    if (typed) due_tokens.push_back(want);
    else for (int i = 0; i < tok_n; i++) due_tokens.push_back(tok_buf[i]);
    bytes_sent++;
    if (item.final_byte) texts_sent++;
  endtask

  task automatic wait_drained();
    while (due_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int s_idle, int r_stall);
    sender_idle = s_idle;
    stall_pct = r_stall;
    plan.delete();
    while (plan.size() < PhaseBytes) compose_text();
    foreach (plan[i]) offer(plan[i], 1'b0, '0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("markup_char_tokenizer_test: done, errors");
        $finish;
      end
    end
  end

  // The long hold-off is counted here, so that the sender keeps offering bytes meanwhile.
  initial begin : result_side
    int hold_left, served;
    hold_left = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_asks) begin
        served = hold_asks;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : token_checker
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      tokens_seen++;
      if (out_data.token_kind == KIND_CMT_OPEN || out_data.token_kind == KIND_CMT_CLOSE)
        comment_tokens++;
      if (due_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected token: kind %0d char %02h starts %0b last %0b done %0b",
                   out_data.token_kind, out_data.char_value, out_data.starts_token,
                   out_data.run_last, out_data.text_done);
      end else begin
        want = due_tokens.pop_front();
        if (out_data.token_kind !== want.token_kind || out_data.char_value !== want.char_value
            || out_data.starts_token !== want.starts_token
            || out_data.run_last !== want.run_last || out_data.text_done !== want.text_done) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("token %0d: expected %0d/%02h/%0b%0b%0b, got %0d/%02h/%0b%0b%0b",
                     tokens_seen, want.token_kind, want.char_value, want.starts_token,
                     want.run_last, want.text_done, out_data.token_kind, out_data.char_value,
                     out_data.starts_token, out_data.run_last, out_data.text_done);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_fixed(8'h00, KIND_TEXT);
    add_fixed(8'hFF, KIND_TEXT);
    add_fixed(CH_GREATER, KIND_GREATER);
    add_fixed(CH_EQUALS, KIND_EQUALS);
    add_fixed(CH_QUOTE, KIND_QUOTE);
    add_fixed(CH_SLASH, KIND_SLASH);
    add_fixed(CH_SPACE, KIND_SPACE);
    add_fixed(CH_LESS, KIND_LESS);
    add_fixed(CH_DASH, KIND_TEXT);
    add_probe(CH_LESS, 1'b0);
    add_probe(CH_BANG, 1'b0);
    add_probe(CH_DASH, 1'b0);
    add_probe(CH_DASH, 1'b0);
    add_probe(CH_DASH, 1'b0);
    add_probe(CH_DASH, 1'b0);
    add_probe(CH_GREATER, 1'b1);
    add_probe(CH_LESS, 1'b0);
    add_probe(CH_BANG, 1'b0);
    add_probe(CH_DASH, 1'b0);
    add_probe(8'h78, 1'b0);
    add_probe(CH_TAB, 1'b0);
    add_probe(CH_CR, 1'b0);
    add_probe(CH_LESS, 1'b0);
    add_probe(CH_BANG, 1'b1);
    foreach (probes[i]) offer(probes[i].item, probes[i].typed, probes[i].want);
    in_valid <= 1'b0;
    wait_drained();

    // The receiver holds off at the start of the first random phase while bytes keep coming.
    hold_asks++;
    run_phase(0, 0);
    run_phase(53, 0);
    run_phase(0, 53);
    run_phase(10, 10);

    repeat (8) @(posedge clk);
    $display("summary: %0d bytes in %0d texts, %0d tokens compared (%0d comment markers)",
             bytes_sent, texts_sent, tokens_seen, comment_tokens);
    $display("summary: %0d mismatches, %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("markup_char_tokenizer_test: done, clean");
    end else begin
      $display("markup_char_tokenizer_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mct_pkg.sv
rtl/mct_scan.sv
rtl/mct_serial.sv
rtl/markup_char_tokenizer.sv
sim/markup_char_tokenizer_test.sv
